// ===== design/sldb_pkg.sv =====
// Shared types, constants and elaboration-time helpers for the sound level meter.
// Used by every module of the sound_level_db_min_max block; depends on nothing.
package sldb_pkg;

  // Input command codes (tuser)
  localparam logic FUNC_MEASURE = 1'b0;
  localparam logic FUNC_RESET   = 1'b1;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 16;
  localparam int POS_W    = 4;
  localparam int FRAC_W   = 16;
  localparam int LOG_W    = POS_W + FRAC_W;

  // ADC code of full scale
  localparam int FULL_SCALE = 32768;

  // Squaring steps of the log2, one pipeline stage each
  localparam int LOG_STAGES = FRAC_W;

  // Front/back queue, power of two
  localparam int QUEUE_DEPTH = 4;

  // 20*log10(2) in Q16
  localparam int DB_LOG_W = 19;
  localparam logic [DB_LOG_W-1:0] DB_PER_LOG2 = 19'd394566;
  localparam int PROD_W = LOG_W + DB_LOG_W;
  localparam int DB_W   = PROD_W - 16;

  // dB constants in Q16
  localparam longint VOLT_SCALE_DB = 285061;   // 20*log10(1.65)
  localparam longint AMP_GAIN_DB   = 2390622;  // 36.478 dB
  localparam longint SENS_DB       = 94 * 65536;
  localparam longint FLOOR_DB      = -104 * 65536;
  localparam longint ROUND_HALF    = 128;

  // Q16 log2 of a constant, same bit-exact squaring scheme as the datapath
  function automatic logic [31:0] log2q_f(input logic [31:0] x);
    logic [31:0] p;
    logic [63:0] m;
    logic [15:0] frac;
    p = 32'd0;
    for (int k = 1; k < 32; k++) begin
      if ((x >> k) != 32'd0) p = 32'(k);
    end
    if (p <= 32'd15) m = 64'(x) << (32'd15 - p);
    else             m = 64'(x >> (p - 32'd15));
    frac = 16'd0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 15;
      frac = {frac[14:0], 1'b0};
      if (m >= 64'd65536) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return {p[15:0], frac};
  endfunction

  // dB of full scale, folded into one accumulator offset with all fixed terms.
  // Offset includes rounding half and the sensitivity shifted up by 8 bits.
  localparam longint DB_FS =
    longint'((64'(log2q_f(32'(FULL_SCALE))) * 64'(DB_PER_LOG2)) >> 16);

  localparam int ACC_W = 26;
  localparam logic signed [ACC_W-1:0] ACC_OFS =
    ACC_W'(VOLT_SCALE_DB - AMP_GAIN_DB - DB_FS + ROUND_HALF + SENS_DB);
  localparam logic signed [ACC_W-1:0] ACC_FLOOR =
    ACC_W'(FLOOR_DB + ROUND_HALF + SENS_DB);
  localparam int Q_W = ACC_W - 8;

  // Normalized sample, front to back
  typedef struct packed {
    logic              func;
    logic              zero;
    logic [POS_W-1:0]  pos;
    logic [15:0]       mant;
  } norm_t;

  // One squaring stage
  typedef struct packed {
    logic              func;
    logic              zero;
    logic [POS_W-1:0]  pos;
    logic [15:0]       mant;
    logic [FRAC_W-1:0] frac;
  } log_stage_t;

  // Finished log2 with its command
  typedef struct packed {
    logic              func;
    logic              zero;
    logic [LOG_W-1:0]  log2q;
  } log_res_t;

endpackage

// ===== design/sldb_front.sv =====
// Front end: input transfer, zero detect, leading-one search and normalization.
// Depends on sldb_pkg; feeds sldb_queue.
module sldb_front (
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [sldb_pkg::SAMPLE_W-1:0] in_tdata,  // [15:0] sample
  input  logic                          in_tuser,  // [0] func
  input  logic                          q_full,
  output logic                          q_push,
  output sldb_pkg::norm_t               q_wdata
);

  logic [sldb_pkg::POS_W-1:0] pos;

  // Accept whenever the queue has room
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Leading-one position
  always_comb begin
    pos = '0;
    for (int k = 0; k < sldb_pkg::SAMPLE_W; k++) begin
      if (in_tdata[k]) pos = sldb_pkg::POS_W'(k);
    end
  end

  // Leading one moved to bit 15
  always_comb begin
    q_wdata.func = in_tuser;
    q_wdata.zero = (in_tdata == '0);
    q_wdata.pos  = pos;
    q_wdata.mant = in_tdata << (sldb_pkg::POS_W'(15) - pos);
  end

endmodule

// ===== design/sldb_queue.sv =====
// Short queue between front end and log2 pipeline, flip-flop storage.
// Depends on sldb_pkg for the entry type and depth.
module sldb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sldb_pkg::norm_t wdata,
  input  logic            pop,
  output sldb_pkg::norm_t rdata,
  output logic            full,
  output logic            empty
);

  localparam int PTR_W = $clog2(sldb_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(sldb_pkg::QUEUE_DEPTH + 1);

  sldb_pkg::norm_t  mem_r [sldb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(sldb_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== design/sldb_log2.sv =====
// Pipelined Q16 log2: one mantissa squaring per stage, one fraction bit each.
// Depends on sldb_pkg; fed by sldb_queue, feeds sldb_back.
module sldb_log2 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  sldb_pkg::norm_t    in_data,
  output logic               out_vld,
  output sldb_pkg::log_res_t out_data
);

  localparam int N = sldb_pkg::LOG_STAGES;

  sldb_pkg::log_stage_t stage_r   [N];
  logic                 stage_vld_r [N];
  sldb_pkg::log_stage_t src       [N];
  logic                 src_vld   [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [31:0]          sq;
    sldb_pkg::log_stage_t stage_nxt;

    // Stage input: queue head or previous stage
    if (i == 0) begin : g_first
      assign src[i]     = {in_data, sldb_pkg::FRAC_W'(0)};
      assign src_vld[i] = in_vld;
    end else begin : g_next
      assign src[i]     = stage_r[i-1];
      assign src_vld[i] = stage_vld_r[i-1];
    end

    // Square, take the integer bit as the next fraction bit
    assign sq = 32'(src[i].mant) * 32'(src[i].mant);
    always_comb begin
      stage_nxt      = src[i];
      stage_nxt.frac = {src[i].frac[sldb_pkg::FRAC_W-2:0], sq[31]};
      stage_nxt.mant = sq[31] ? sq[31:16] : sq[30:15];
    end

    always_ff @(posedge clk) begin
      if (en) stage_r[i] <= stage_nxt;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_vld_r[i] <= 1'b0;
      end else if (en) begin
        stage_vld_r[i] <= src_vld[i];
      end
    end
  end

  assign out_vld        = stage_vld_r[N-1];
  assign out_data.func  = stage_r[N-1].func;
  assign out_data.zero  = stage_r[N-1].zero;
  assign out_data.log2q = {stage_r[N-1].pos, stage_r[N-1].frac};

endmodule

// ===== design/sldb_back.sv =====
// Back end: log2 to dB, offsets, floor, saturation, min/max hold, output register.
// Depends on sldb_pkg; fed by sldb_log2. Holds the calibration register.
module sldb_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [sldb_pkg::LEVEL_W-1:0] cfg_wdata,
  input  logic                         in_vld,
  input  sldb_pkg::log_res_t           in_data,
  output logic                         en,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [3*sldb_pkg::LEVEL_W-1:0] out_tdata
);

  localparam int LW = sldb_pkg::LEVEL_W;
  localparam int AW = sldb_pkg::ACC_W;
  localparam int QW = sldb_pkg::Q_W;
  localparam int DW = QW + 1;

  logic signed [LW-1:0] cal_r;

  logic                        a_vld_r;
  logic                        a_func_r;
  logic                        a_zero_r;
  logic [sldb_pkg::PROD_W-1:0] a_prod_r;

  logic                 b_vld_r;
  logic                 b_func_r;
  logic signed [QW-1:0] b_q_r;

  logic                 c_vld_r;
  logic                 c_func_r;
  logic signed [LW-1:0] c_level_r;

  logic                 track_r;
  logic signed [LW-1:0] lowest_r;
  logic signed [LW-1:0] highest_r;
  logic                 out_vld_r;
  logic signed [LW-1:0] out_level_r;
  logic signed [LW-1:0] out_min_r;
  logic signed [LW-1:0] out_max_r;

  logic [sldb_pkg::DB_W-1:0] db;
  logic signed [AW-1:0]      acc;
  logic signed [AW-1:0]      acc_fl;
  logic signed [DW-1:0]      diff;
  logic signed [LW-1:0]      level_nxt;
  logic                      restart;
  logic signed [LW-1:0]      lowest_nxt;
  logic signed [LW-1:0]      highest_nxt;

  // Whole pipeline advances unless a result is stuck at the output
  assign en = !out_vld_r || out_tready;

  // Calibration register
  always_ff @(posedge clk) begin
    if (!rst_n) cal_r <= LW'(-10752);
    else if (cfg_we) cal_r <= cfg_wdata;
  end

  // Stage A: log2 times 20*log10(2)
  always_ff @(posedge clk) begin
    if (en) begin
      a_func_r <= in_data.func;
      a_zero_r <= in_data.zero;
      a_prod_r <= sldb_pkg::PROD_W'(in_data.log2q) * sldb_pkg::PROD_W'(sldb_pkg::DB_PER_LOG2);
    end
  end

  // Stage B: add fixed offsets, apply the floor, drop to Q8
  assign db  = a_prod_r[sldb_pkg::PROD_W-1:16];
  assign acc = signed'(AW'(db)) + sldb_pkg::ACC_OFS;
  assign acc_fl = (a_zero_r || acc < sldb_pkg::ACC_FLOOR) ? sldb_pkg::ACC_FLOOR : acc;

  always_ff @(posedge clk) begin
    if (en) begin
      b_func_r <= a_func_r;
      b_q_r    <= acc_fl[AW-1:8];
    end
  end

  // Stage C: subtract calibration, saturate to 16 bits
  assign diff = DW'(b_q_r) - DW'(cal_r);
  always_comb begin
    if (diff > DW'(32767))       level_nxt = 16'sh7FFF;
    else if (diff < DW'(-32768)) level_nxt = 16'sh8000;
    else                         level_nxt = diff[LW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_func_r  <= b_func_r;
      c_level_r <= level_nxt;
    end
  end

  // Stage D: min/max hold
  assign restart     = (c_func_r == sldb_pkg::FUNC_RESET) || !track_r;
  assign lowest_nxt  = (restart || c_level_r < lowest_r)  ? c_level_r : lowest_r;
  assign highest_nxt = (restart || c_level_r > highest_r) ? c_level_r : highest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r   <= 1'b0;
      lowest_r  <= '0;
      highest_r <= '0;
    end else if (en && c_vld_r) begin
      track_r   <= 1'b1;
      lowest_r  <= lowest_nxt;
      highest_r <= highest_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && c_vld_r) begin
      out_level_r <= c_level_r;
      out_min_r   <= lowest_nxt;
      out_max_r   <= highest_nxt;
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r   <= in_vld;
      b_vld_r   <= a_vld_r;
      c_vld_r   <= b_vld_r;
      out_vld_r <= c_vld_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_max_r, out_min_r, out_level_r};

endmodule

// ===== design/sound_level_db_min_max.sv =====
// Top level of the sound level meter with min/max hold.
// Depends on sldb_pkg, sldb_front, sldb_queue, sldb_log2 and sldb_back.
//
//  channel   dir   handshake             payload
//  in_       in    in_tvalid/in_tready   tdata: sample[15:0]; tuser: func
//  out_      out   out_tvalid/out_tready tdata: level, min_level, max_level
//  cfg_      in    cfg_we                cfg_wdata: mic_calibration
//
// One item per cycle sustained while the output is taken; each squaring step of the
// log2 is one 16x16 multiplier stage, so the pipeline holds 16 such stages plus four more.
// From input transfer to result valid an item passes the 16 log2 stages, then the
// dB product, offset/floor, calibration/saturation and min/max hold registers;
// the queue entry is written at the transfer edge itself.
// Reset clears valid bits, the queue and the min/max tracking; no sweep.
// out_tready low with a result held freezes the whole pipeline; the 4-entry queue then fills and
// in_tready drops.
module sound_level_db_min_max (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] level, [31:16] min_level, [47:32] max_level
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata   // [15:0] mic_calibration
);

  sldb_pkg::norm_t    q_wdata;
  sldb_pkg::norm_t    q_rdata;
  sldb_pkg::log_res_t log_data;
  logic               q_push;
  logic               q_full;
  logic               q_empty;
  logic               en;
  logic               log_vld;

  sldb_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  sldb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (en),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  sldb_log2 u_log2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (!q_empty),
    .in_data  (q_rdata),
    .out_vld  (log_vld),
    .out_data (log_data)
  );

  sldb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_vld     (log_vld),
    .in_data    (log_data),
    .en         (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sound_level_db_min_max: directed table, then random phases.
// Depends on sldb_pkg and the block's RTL; predicts each result on its own unless a table row types it.
module testbench;

  // Result layout on out_tdata, lowest field last
  typedef struct packed {
    logic [15:0] max_l;
    logic [15:0] min_l;
    logic [15:0] level;
  } meter_out_t;

  // One row of the directed table
  typedef struct packed {
    logic        func;
    logic [15:0] sample;
    logic        set_cal;
    logic [15:0] cal;
    logic        fixed;
    meter_out_t  typed;
  } stim_row_t;

  localparam longint     DBV_FLOOR_Q16   = -104 * 65536;
  localparam longint     VOLT_DB_Q16     = 285061;    // 20*log10(1.65)
  localparam longint     GAIN_DB_Q16     = 2390622;   // amplifier gain 36.478 dB
  localparam longint     DB_PER_OCT_Q16  = 394566;    // 20*log10(2)
  localparam longint     SENS_Q8         = 94 * 256;
  localparam logic [15:0] CAL_AT_RESET   = 16'(-10752);
  localparam logic [15:0] CAL_LOWEST     = 16'(-25600);
  localparam int         SETTLE_CYCLES   = 24;
  localparam int         NUM_PHASES      = 6;
  localparam int         ITEMS_PER_PHASE = 237;
  localparam int         HOLD_AFTER      = 1150;
  localparam int         HOLD_CYCLES     = 200;
  localparam int         CYCLE_LIMIT     = 200000;
  localparam int         NUM_DIRECTED    = 25;
  localparam meter_out_t NO_TYPED        = '0;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [15:0] sample
  logic        in_tuser;   // [0] func
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [15:0] level, [31:16] min_level, [47:32] max_level
  logic        cfg_we;
  logic [15:0] cfg_wdata;  // [15:0] mic_calibration

  sound_level_db_min_max dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // Predictor state
  logic signed [15:0] cal_q88;
  logic signed [15:0] low_hold;
  logic signed [15:0] high_hold;
  logic               tracking;

  meter_out_t pending_levels[$];
  int         mismatches = 0;
  int         results_seen = 0;
  int         cycle_count = 0;
  int         send_gap_pct;
  int         recv_stall_pct;
  int         drain_wait;
  logic       next_func;
  logic [15:0] phase_cal;
  meter_out_t got;
  meter_out_t want;

  // Directed table: extremes, both commands, floor region, saturation both ways
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    // first transfer after reset acts as reset; zero sample sits on the floor
    '{sldb_pkg::FUNC_MEASURE, 16'h0000, 1'b0, 16'h0000, 1'b1, '{16'h2000, 16'h2000, 16'h2000}},
    '{sldb_pkg::FUNC_MEASURE, 16'h8000, 1'b0, 16'h0000, 1'b0, NO_TYPED},
    '{sldb_pkg::FUNC_MEASURE, 16'h0001, 1'b0, 16'h0000, 1'b0, NO_TYPED},
    '{sldb_pkg::FUNC_MEASURE, 16'hFFFF, 1'b0, 16'h0000, 1'b0, NO_TYPED},
    '{sldb_pkg::FUNC_MEASURE, 16'h7FFF, 1'b0, 16'h0000, 1'b0, NO_TYPED},
    '{sldb_pkg::FUNC_MEASURE, 16'h5555, 1'b0, 16'h0000, 1'b0, NO_TYPED},
    '{sldb_pkg::FUNC_MEASURE, 16'hAAAA, 1'b0, 16'h0000, 1'b0, NO_TYPED},
    // around the floor knee
    '{sldb_pkg::FUNC_MEASURE, 16'h0008, 1'b0, 16'h0000, 1'b0, NO_TYPED},
    '{sldb_pkg::FUNC_MEASURE, 16'h0009, 1'b0, 16'h0000, 1'b0, NO_TYPED},
    '{sldb_pkg::FUNC_MEASURE, 16'h000A, 1'b0, 16'h0000, 1'b0, NO_TYPED},
    '{sldb_pkg::FUNC_RESET,   16'd1000, 1'b0, 16'h0000, 1'b0, NO_TYPED},
    '{sldb_pkg::FUNC_MEASURE, 16'd2000, 1'b0, 16'h0000, 1'b0, NO_TYPED},
    '{sldb_pkg::FUNC_MEASURE, 16'd500,  1'b0, 16'h0000, 1'b0, NO_TYPED},
    '{sldb_pkg::FUNC_RESET,   16'h0000, 1'b0, 16'h0000, 1'b1, '{16'h2000, 16'h2000, 16'h2000}},
    '{sldb_pkg::FUNC_MEASURE, 16'h0000, 1'b0, 16'h0000, 1'b1, '{16'h2000, 16'h2000, 16'h2000}},
    '{sldb_pkg::FUNC_MEASURE, 16'h0002, 1'b0, 16'h0000, 1'b0, NO_TYPED},
    '{sldb_pkg::FUNC_MEASURE, 16'h00FF, 1'b0, 16'h0000, 1'b0, NO_TYPED},
    '{sldb_pkg::FUNC_MEASURE, 16'h0100, 1'b0, 16'h0000, 1'b0, NO_TYPED},
    // largest calibration drives the floor below the negative limit
    '{sldb_pkg::FUNC_RESET,   16'h0000, 1'b1, 16'h7FFF, 1'b1, '{16'h8000, 16'h8000, 16'h8000}},
    '{sldb_pkg::FUNC_MEASURE, 16'h8000, 1'b0, 16'h0000, 1'b0, NO_TYPED},
    // most negative calibration pushes full scale past the positive limit
    '{sldb_pkg::FUNC_RESET,   16'h8000, 1'b1, 16'h8000, 1'b1, '{16'h7FFF, 16'h7FFF, 16'h7FFF}},
    '{sldb_pkg::FUNC_MEASURE, 16'h0000, 1'b0, 16'h0000, 1'b0, NO_TYPED},
    '{sldb_pkg::FUNC_RESET,   16'h4000, 1'b1, CAL_LOWEST, 1'b0, NO_TYPED},
    '{sldb_pkg::FUNC_MEASURE, 16'hFFFF, 1'b0, 16'h0000, 1'b0, NO_TYPED},
    '{sldb_pkg::FUNC_RESET,   16'h1234, 1'b1, 16'h0000, 1'b0, NO_TYPED}
  };

  // Clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Q16 log2 by repeated squaring of the normalized mantissa
  function automatic longint unsigned log2_q16(input logic [15:0] x);
    int unsigned lead;
    logic [63:0] mant;
    logic [15:0] frac;
    lead = 0;
    for (int b = 0; b < 16; b++) begin
      if (x[b]) lead = b;
    end
    mant = 64'(x) << (15 - lead);
    frac = '0;
    repeat (16) begin
      mant = (mant * mant) >> 15;
      frac = {frac[14:0], 1'b0};
      if (mant >= 64'd65536) begin
        frac[0] = 1'b1;
        mant = mant >> 1;
      end
    end
    return (longint'(lead) << 16) | longint'(frac);
  endfunction

  function automatic longint db_q16(input logic [15:0] x);
    return longint'((log2_q16(x) * longint'(DB_PER_OCT_Q16)) >> 16);
  endfunction

  // Level in Q8.8 dB SPL for one sample under a given calibration
  function automatic logic signed [15:0] spl_q88(input logic [15:0] s,
                                                 input logic signed [15:0] cal);
    longint dbv;
    longint spl;
    if (s == 16'd0) begin
      dbv = DBV_FLOOR_Q16;
    end else begin
      dbv = db_q16(s) - db_q16(16'(sldb_pkg::FULL_SCALE)) + VOLT_DB_Q16 - GAIN_DB_Q16;
      if (dbv < DBV_FLOOR_Q16) dbv = DBV_FLOOR_Q16;
    end
    spl = ((dbv + 128) >>> 8) + SENS_Q8 - longint'(cal);
    if (spl > 32767) spl = 32767;
    else if (spl < -32768) spl = -32768;
    return 16'(spl);
  endfunction

  // Advance min/max hold by one sample and return the expected result
  task automatic meter_step(input logic f, input logic [15:0] s, output meter_out_t res);
    logic signed [15:0] lvl;
    lvl = spl_q88(s, cal_q88);
    if (f == sldb_pkg::FUNC_RESET || !tracking) begin
      low_hold  = lvl;
      high_hold = lvl;
      tracking  = 1'b1;
    end else begin
      if (lvl < low_hold)  low_hold  = lvl;
      if (lvl > high_hold) high_hold = lvl;
    end
    res.level = lvl;
    res.min_l = low_hold;
    res.max_l = high_hold;
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] expv,
                                 input logic [15:0] gotv);
    mismatches++;
    if (mismatches <= 100)
      $display("MISMATCH %s: expected %h, got %h (result %0d)",
               what, expv, gotv, results_seen);
  endtask

  // Random sample: zero, floor region, near full scale, full 16 bits, log-spread, uniform
  function automatic logic [15:0] pick_sample();
    int unsigned k;
    logic [15:0] s;
    case ($urandom_range(0, 9))
      0: s = 16'h0000;
      1: s = 16'($urandom_range(1, 16));
      2: s = 16'($urandom_range(32000, 32768));
      3: s = 16'($urandom);
      4, 5, 6: begin
        k = $urandom_range(0, 15);
        s = 16'((32'd1 << k) | ($urandom & ((32'd1 << k) - 32'd1)));
      end
      default: s = 16'($urandom_range(0, 32768));
    endcase
    return s;
  endfunction

  // Offer one sample; called and returns at a falling edge
  task automatic offer_sample(input logic f, input logic [15:0] s, input logic fixed,
                              input meter_out_t typed);
    meter_out_t res;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    meter_step(f, s, res);
    pending_levels.push_back(fixed ? typed : res);
    @(negedge clk);
  endtask

  // Calibration write once all results are out and the pipe has settled
  task automatic write_calibration(input logic [15:0] value);
    in_tvalid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we  <= 1'b0;
    cal_q88 = value;
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      got = meter_out_t'(out_tdata);
      if (pending_levels.size() == 0) begin
        report_mismatch("unexpected transfer, level", 16'h0000, got.level);
      end else begin
        want = pending_levels.pop_front();
        if (got.level !== want.level) report_mismatch("level", want.level, got.level);
        if (got.min_l !== want.min_l) report_mismatch("min_level", want.min_l, got.min_l);
        if (got.max_l !== want.max_l) report_mismatch("max_level", want.max_l, got.max_l);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off to back up the input
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (results_seen >= HOLD_AFTER && results_seen < HOLD_AFTER + 5) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_tready <= 1'b1;
        while (results_seen < HOLD_AFTER + 5) @(negedge clk);
      end
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = sldb_pkg::FUNC_MEASURE;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    cal_q88        = CAL_AT_RESET;
    low_hold       = '0;
    high_hold      = '0;
    tracking       = 1'b0;
    send_gap_pct   = 20;
    recv_stall_pct = 67;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_cal) write_calibration(directed_rows[i].cal);
      offer_sample(directed_rows[i].func, directed_rows[i].sample,
                   directed_rows[i].fixed, directed_rows[i].typed);
    end

    // Random phases: each under its own calibration; idle profile shared by pairs of phases
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph / 2)
        0: begin
          send_gap_pct   = 20;
          recv_stall_pct = 67;
        end
        1: begin
          send_gap_pct   = 67;
          recv_stall_pct = 20;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      case (ph)
        0:       phase_cal = CAL_AT_RESET;
        1:       phase_cal = CAL_LOWEST;
        2:       phase_cal = 16'h0000;
        default: phase_cal = 16'(-int'($urandom_range(0, 25600)));
      endcase
      write_calibration(phase_cal);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // software normally restarts tracking after a calibration write
        if (n == 0)
          next_func = ($urandom_range(0, 3) != 0) ? sldb_pkg::FUNC_RESET
                                                  : sldb_pkg::FUNC_MEASURE;
        else
          next_func = ($urandom_range(0, 9) == 0) ? sldb_pkg::FUNC_RESET
                                                  : sldb_pkg::FUNC_MEASURE;
        offer_sample(next_func, pick_sample(), 1'b0, NO_TYPED);
      end
    end
    in_tvalid <= 1'b0;

    // Drain, then let the pipe settle
    drain_wait = 0;
    while (pending_levels.size() != 0 && drain_wait < 20000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (pending_levels.size() != 0)
      report_mismatch("results never arrived, count", 16'h0000,
                      16'(pending_levels.size()));

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
